[rtl/srq_pkg.sv]
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and constants for the slot ring queue with bad-slot skipping.
// ----------------------------------------------------------------------------
package srq_pkg;

    // Ring geometry
    localparam int SLOTS      = 64;
    localparam int SLOT_BYTES = 64;
    localparam int HDR_BYTES  = 5;
    localparam int SLOT_W     = $clog2(SLOTS);

    // Field widths
    localparam int BAD_W  = 6;
    localparam int IDX_W  = 6;
    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;
    localparam int OVF_W  = 8;
    localparam int TOT_W  = 16;
    localparam int DESC_W = 2 * BYTE_W;

    localparam logic [CNT_W-1:0]  CNT_SAT      = '1;
    localparam logic [BYTE_W-1:0] MAX_PAY_RST  = 8'd58;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        FLAG_FREE = 2'd0,
        FLAG_USED = 2'd1,
        FLAG_BAD  = 2'd2
    } flag_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_BAD_LEN  = 3'd1,
        STS_FULL     = 3'd2,
        STS_BUSY     = 3'd3,
        STS_EMPTY    = 3'd4,
        STS_FREE     = 3'd5,
        STS_ALL_BAD  = 3'd6
    } status_t;

    // Write port of the flag memory
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        flag_t             data;
    } flag_wr_t;

    // Write port of the descriptor memory
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [DESC_W-1:0] data;
    } desc_wr_t;

    // Ring successor of a slot
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    // Payload address of a slot: past the slot header
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
        int unsigned a;
        a = int'(s) * SLOT_BYTES + HDR_BYTES;
        return a[ADDR_W-1:0];
    endfunction

endpackage

[rtl/srq_flag_ram.sv]
// ----------------------------------------------------------------------------
// srq_flag_ram
// Slot flag memory: one write and one registered read per cycle. A per-entry
// valid bit, cleared by reset, makes an unwritten entry read as free.
// ----------------------------------------------------------------------------
module srq_flag_ram
    import srq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  flag_wr_t          wr,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output flag_t             rd_data
);

    flag_t            flag_mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    flag_t            rd_data_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.we)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // Array write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            flag_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? flag_mem[rd_addr] : FLAG_FREE;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/srq_desc_ram.sv]
// ----------------------------------------------------------------------------
// srq_desc_ram
// Slot descriptor memory holding length and type: one write and one
// registered read per cycle, contents undefined until written.
// ----------------------------------------------------------------------------
module srq_desc_ram
    import srq_pkg::*;
(
    input  logic              clk,
    input  desc_wr_t          wr,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [DESC_W-1:0] rd_data
);

    logic [DESC_W-1:0] desc_mem [SLOTS];
    logic [DESC_W-1:0] rd_data_reg;

    // Array write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            desc_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= desc_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/slot_ring_queue_bad_skip.sv]
// ----------------------------------------------------------------------------
// slot_ring_queue_bad_skip
// Ring queue over fixed slots with bad-slot skipping and running counters.
// ----------------------------------------------------------------------------
// One command is handled at a time. Enqueue and dequeue pass through accept,
// flag read, check and result load; every bad slot walked over adds another
// flag read and check, because each step of the walk waits on the registered
// read of the flag memory; a walk visits at most 64 slots. Rejected
// enqueue/dequeue, mark-bad and reset-queue go from accept straight to result
// load. Result load waits until the output register is free.
// A new command is taken as soon as the previous one has loaded its result
// into the output register, so a result waiting on out_ready does not block
// the input until the next result is ready to be loaded.
// ----------------------------------------------------------------------------
module slot_ring_queue_bad_skip
    import srq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    // command channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [BYTE_W-1:0] payload_length,
    input  logic [BYTE_W-1:0] payload_type,
    input  logic [BAD_W-1:0]  bad_slot,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [IDX_W-1:0]  slot_index,
    output logic [ADDR_W-1:0] data_address,
    output logic [BYTE_W-1:0] item_length,
    output logic [BYTE_W-1:0] item_type,
    output logic [CNT_W-1:0]  count_current,
    output logic [CNT_W-1:0]  count_max,
    output logic [OVF_W-1:0]  count_overflow,
    output logic [TOT_W-1:0]  count_queued,
    output logic [TOT_W-1:0]  count_dequeued
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]  typ_reg, typ_next;
    logic [BAD_W-1:0]   bad_reg, bad_next;
    logic [SLOT_W-1:0]  ptr_reg, ptr_next;
    logic [SLOT_W-1:0]  walk_reg, walk_next;

    logic [SLOT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [SLOT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]   peak_reg, peak_next;
    logic [OVF_W-1:0]   full_reg, full_next;
    logic [TOT_W-1:0]   enq_reg, enq_next;
    logic [TOT_W-1:0]   deq_reg, deq_next;
    logic [BYTE_W-1:0]  max_pay_reg, max_pay_next;

    status_t            res_sts_reg, res_sts_next;
    logic [IDX_W-1:0]   res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [BYTE_W-1:0]  res_len_reg, res_len_next;
    logic [BYTE_W-1:0]  res_typ_reg, res_typ_next;

    logic               out_valid_reg, out_valid_next;
    status_t            sts_out_reg, sts_out_next;
    logic [IDX_W-1:0]   slot_out_reg, slot_out_next;
    logic [ADDR_W-1:0]  addr_out_reg, addr_out_next;
    logic [BYTE_W-1:0]  len_out_reg, len_out_next;
    logic [BYTE_W-1:0]  typ_out_reg, typ_out_next;
    logic [CNT_W-1:0]   cur_out_reg, cur_out_next;
    logic [CNT_W-1:0]   max_out_reg, max_out_next;
    logic [OVF_W-1:0]   ovf_out_reg, ovf_out_next;
    logic [TOT_W-1:0]   enq_out_reg, enq_out_next;
    logic [TOT_W-1:0]   deq_out_reg, deq_out_next;

    flag_wr_t           flag_wr;
    desc_wr_t           desc_wr;
    logic               mem_rd_en;
    flag_t              flag_rd;
    logic [DESC_W-1:0]  desc_rd;

    logic               out_free;
    logic [SLOT_W-1:0]  ptr_adv;
    logic [CNT_W-1:0]   held_inc;
    logic               mark_ok;
    logic               commit;

    // Memories
    srq_flag_ram u_flag_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (flag_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (flag_rd)
    );

    srq_desc_ram u_desc_ram (
        .clk     (clk),
        .wr      (desc_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (desc_rd)
    );

    // Handshake and helpers
    assign in_ready  = (state_reg == S_IDLE);
    assign mem_rd_en = (state_reg == S_READ);
    assign out_free  = !out_valid_reg || out_ready;
    assign ptr_adv   = next_slot(ptr_reg);
    assign held_inc  = (held_reg == CNT_SAT) ? held_reg : held_reg + 1'b1;
    assign mark_ok   = (32'(bad_reg) < SLOTS);
    assign commit    = (state_reg == S_FINISH) && out_free;

    // Write-back at result load
    always_comb
    begin
        flag_wr.we   = 1'b0;
        flag_wr.addr = ptr_reg;
        flag_wr.data = FLAG_FREE;
        desc_wr.we   = 1'b0;
        desc_wr.addr = ptr_reg;
        desc_wr.data = {len_reg, typ_reg};
        if (commit)
        begin
            case (cmd_reg)
                CMD_ENQ:
                begin
                    flag_wr.we   = (res_sts_reg == STS_OK);
                    flag_wr.data = FLAG_USED;
                    desc_wr.we   = (res_sts_reg == STS_OK);
                end
                CMD_DEQ:
                begin
                    flag_wr.we   = (res_sts_reg == STS_OK);
                    flag_wr.data = FLAG_FREE;
                end
                CMD_MARK:
                begin
                    flag_wr.we   = mark_ok;
                    flag_wr.addr = SLOT_W'(bad_reg);
                    flag_wr.data = FLAG_BAD;
                end
                default:
                begin
                    flag_wr.we = 1'b0;
                end
            endcase
        end
    end

    // Command sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        typ_next      = typ_reg;
        bad_next      = bad_reg;
        ptr_next      = ptr_reg;
        walk_next     = walk_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        held_next     = held_reg;
        peak_next     = peak_reg;
        full_next     = full_reg;
        enq_next      = enq_reg;
        deq_next      = deq_reg;
        max_pay_next  = cfg_we ? cfg_wdata : max_pay_reg;
        res_sts_next  = res_sts_reg;
        res_slot_next = res_slot_reg;
        res_addr_next = res_addr_reg;
        res_len_next  = res_len_reg;
        res_typ_next  = res_typ_reg;

        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        sts_out_next   = sts_out_reg;
        slot_out_next  = slot_out_reg;
        addr_out_next  = addr_out_reg;
        len_out_next   = len_out_reg;
        typ_out_next   = typ_out_reg;
        cur_out_next   = cur_out_reg;
        max_out_next   = max_out_reg;
        ovf_out_next   = ovf_out_reg;
        enq_out_next   = enq_out_reg;
        deq_out_next   = deq_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd_t'(cmd);
                    len_next      = payload_length;
                    typ_next      = payload_type;
                    bad_next      = bad_slot;
                    walk_next     = '0;
                    res_sts_next  = STS_OK;
                    res_slot_next = '0;
                    res_addr_next = '0;
                    res_len_next  = '0;
                    res_typ_next  = '0;
                    state_next    = S_FINISH;
                    case (cmd_t'(cmd))
                        CMD_ENQ:
                        begin
                            if (payload_length == '0 || payload_length > max_pay_reg)
                            begin
                                res_sts_next = STS_BAD_LEN;
                            end
                            else if (wr_ptr_reg == rd_ptr_reg && held_reg != '0)
                            begin
                                full_next    = full_reg + 1'b1;
                                res_sts_next = STS_FULL;
                            end
                            else
                            begin
                                ptr_next   = wr_ptr_reg;
                                state_next = S_READ;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (rd_ptr_reg == wr_ptr_reg && held_reg == '0)
                            begin
                                res_sts_next = STS_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = rd_ptr_reg;
                                state_next = S_READ;
                            end
                        end
                        CMD_MARK:
                        begin
                            if (32'(bad_slot) < SLOTS)
                            begin
                                res_slot_next = IDX_W'(bad_slot);
                            end
                        end
                        default:
                        begin
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                            held_next   = '0;
                            peak_next   = '0;
                            full_next   = '0;
                            enq_next    = '0;
                            deq_next    = '0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                state_next = S_FINISH;
                if (flag_rd == FLAG_BAD)
                begin
                    // walk on, or give up after a whole lap
                    if (walk_reg == SLOT_W'(SLOTS - 1))
                    begin
                        res_sts_next  = STS_ALL_BAD;
                        res_slot_next = IDX_W'(ptr_adv);
                        if (cmd_reg == CMD_ENQ)
                        begin
                            wr_ptr_next = ptr_adv;
                        end
                        else
                        begin
                            rd_ptr_next = ptr_adv;
                        end
                    end
                    else
                    begin
                        ptr_next   = ptr_adv;
                        walk_next  = walk_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    res_slot_next = IDX_W'(ptr_reg);
                    if (cmd_reg == CMD_ENQ)
                    begin
                        if (flag_rd == FLAG_USED)
                        begin
                            res_sts_next = STS_BUSY;
                            wr_ptr_next  = ptr_reg;
                        end
                        else
                        begin
                            res_sts_next  = STS_OK;
                            res_addr_next = slot_addr(ptr_reg);
                            res_len_next  = len_reg;
                            held_next     = held_inc;
                            peak_next     = (held_inc > peak_reg) ? held_inc : peak_reg;
                            enq_next      = enq_reg + 1'b1;
                            wr_ptr_next   = ptr_adv;
                        end
                    end
                    else
                    begin
                        if (flag_rd != FLAG_USED)
                        begin
                            res_sts_next = STS_FREE;
                            rd_ptr_next  = ptr_reg;
                        end
                        else
                        begin
                            res_sts_next  = STS_OK;
                            res_addr_next = slot_addr(ptr_reg);
                            res_len_next  = desc_rd[DESC_W-1:BYTE_W];
                            res_typ_next  = desc_rd[BYTE_W-1:0];
                            held_next     = (held_reg == '0) ? held_reg : held_reg - 1'b1;
                            deq_next      = deq_reg + 1'b1;
                            rd_ptr_next   = ptr_adv;
                        end
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sts_out_next   = res_sts_reg;
                    slot_out_next  = res_slot_reg;
                    addr_out_next  = res_addr_reg;
                    len_out_next   = res_len_reg;
                    typ_out_next   = res_typ_reg;
                    cur_out_next   = held_reg;
                    max_out_next   = peak_reg;
                    ovf_out_next   = full_reg;
                    enq_out_next   = enq_reg;
                    deq_out_next   = deq_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_ENQ;
            len_reg       <= '0;
            typ_reg       <= '0;
            bad_reg       <= '0;
            ptr_reg       <= '0;
            walk_reg      <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            held_reg      <= '0;
            peak_reg      <= '0;
            full_reg      <= '0;
            enq_reg       <= '0;
            deq_reg       <= '0;
            max_pay_reg   <= MAX_PAY_RST;
            res_sts_reg   <= STS_OK;
            res_slot_reg  <= '0;
            res_addr_reg  <= '0;
            res_len_reg   <= '0;
            res_typ_reg   <= '0;
            out_valid_reg <= 1'b0;
            sts_out_reg   <= STS_OK;
            slot_out_reg  <= '0;
            addr_out_reg  <= '0;
            len_out_reg   <= '0;
            typ_out_reg   <= '0;
            cur_out_reg   <= '0;
            max_out_reg   <= '0;
            ovf_out_reg   <= '0;
            enq_out_reg   <= '0;
            deq_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            typ_reg       <= typ_next;
            bad_reg       <= bad_next;
            ptr_reg       <= ptr_next;
            walk_reg      <= walk_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            held_reg      <= held_next;
            peak_reg      <= peak_next;
            full_reg      <= full_next;
            enq_reg       <= enq_next;
            deq_reg       <= deq_next;
            max_pay_reg   <= max_pay_next;
            res_sts_reg   <= res_sts_next;
            res_slot_reg  <= res_slot_next;
            res_addr_reg  <= res_addr_next;
            res_len_reg   <= res_len_next;
            res_typ_reg   <= res_typ_next;
            out_valid_reg <= out_valid_next;
            sts_out_reg   <= sts_out_next;
            slot_out_reg  <= slot_out_next;
            addr_out_reg  <= addr_out_next;
            len_out_reg   <= len_out_next;
            typ_out_reg   <= typ_out_next;
            cur_out_reg   <= cur_out_next;
            max_out_reg   <= max_out_next;
            ovf_out_reg   <= ovf_out_next;
            enq_out_reg   <= enq_out_next;
            deq_out_reg   <= deq_out_next;
        end
    end

    // Output beat
    assign out_valid      = out_valid_reg;
    assign status         = sts_out_reg;
    assign slot_index     = slot_out_reg;
    assign data_address   = addr_out_reg;
    assign item_length    = len_out_reg;
    assign item_type      = typ_out_reg;
    assign count_current  = cur_out_reg;
    assign count_max      = max_out_reg;
    assign count_overflow = ovf_out_reg;
    assign count_queued   = enq_out_reg;
    assign count_dequeued = deq_out_reg;

    // Checks
    a_peak_covers_held: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= held_reg)
        else $error("peak count below held count");

    a_beat_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result beat loaded outside finish");

    a_check_exits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |=> state_reg == S_READ || state_reg == S_FINISH)
        else $error("bad exit from check");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(flag_wr.we && mem_rd_en))
        else $error("flag write during walk read");

endmodule
